### src/tce_pkg.sv
// ----------------------------------------------------------------------------
// Torsion energy core package
// Shared widths, payload types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

  localparam int CFG_COUNT = 7;

  localparam logic [2:0] REG_T_ZERO  = 3'd0;
  localparam logic [2:0] REG_T_ONE   = 3'd1;
  localparam logic [2:0] REG_T_TWO   = 3'd2;
  localparam logic [2:0] REG_T_THREE = 3'd3;
  localparam logic [2:0] REG_U_ZERO  = 3'd4;
  localparam logic [2:0] REG_U_ONE   = 3'd5;
  localparam logic [2:0] REG_U_TWO   = 3'd6;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
  localparam logic [30:0]        SIN_FLOOR   = 31'd1074;

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 64;

  typedef logic signed [31:0] coef_t;
  typedef logic signed [33:0] term_t;
  typedef logic signed [35:0] sum_t;
  typedef logic signed [37:0] rnd_t;
  typedef logic signed [41:0] esum_t;
  typedef logic signed [65:0] acc_t;
  typedef logic signed [67:0] wide_t;
  typedef logic        [60:0] rad_t;
  typedef logic        [30:0] rem_t;

  typedef struct packed {
    coef_t t0;
    coef_t t1;
    coef_t t2;
    coef_t t3;
    coef_t u0;
    coef_t u1;
    coef_t u2;
  } coef_set_t;

  typedef struct packed {
    logic signed [31:0] c;
    sum_t               tv;
    sum_t               td;
    sum_t               uv;
    sum_t               ud;
  } poly_t;

  typedef struct packed {
    esum_t esum;
    esum_t spart;
    logic  neg;
  } div_side_t;

  function automatic rnd_t rnd30(input wide_t v);
    wide_t t;
    t = v + 68'sd536870912;
    return rnd_t'(t >>> 30);
  endfunction

  function automatic logic [63:0] sat64(input acc_t v);
    logic [63:0] r;
    if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
      r = v[63:0];
    end else if (v[65]) begin
      r = {1'b1, 63'b0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tce_if.sv
// ----------------------------------------------------------------------------
// Torsion energy core channels
// Request channel (cosine) and response channel (energy, slope).
// ----------------------------------------------------------------------------
`default_nettype none

interface tce_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cos_angle;

  modport source (output valid, output cos_angle, input ready);
  modport sink   (input valid, input cos_angle, output ready);
endinterface

interface tce_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] energy;
  logic signed [63:0] energy_slope;

  modport source (output valid, output energy, output energy_slope, input ready);
  modport sink   (input valid, input energy, input energy_slope, output ready);
endinterface

`default_nettype wire

### src/torsion_chebyshev_energy_force_core.sv
// Throughput: one request per cycle while the response is not stalled;
// the square root (31 stages) and the cosine-term divider (64 stages)
// are fully pipelined, one bit per stage.
// A response stall freezes the whole pipeline; in_req.ready = !out valid | out ready.
// Reset (rst_n low, synchronous) clears all valid bits and zeroes the coefficients.
// ----------------------------------------------------------------------------
// Torsion energy and slope core
// Cosine in, torsion energy and its derivative with respect to cosine out.
// ----------------------------------------------------------------------------
`default_nettype none

module torsion_chebyshev_energy_force_core #(
  parameter int MAX_DEGREE = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  tce_req_if.sink     in_req,
  tce_rsp_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic en;

  tce_pkg::coef_t     coef_r [0:tce_pkg::CFG_COUNT-1];
  tce_pkg::coef_set_t coef_use;

  logic           poly_v;
  tce_pkg::poly_t poly_side;
  tce_pkg::rad_t  poly_rad;

  logic           root_v;
  tce_pkg::poly_t root_side;
  logic [30:0]    root;

  logic           v0_r, v1_r, v2_r, v3_r;
  tce_pkg::poly_t side0_r;
  logic [30:0]    s0_r, s2_r, s3_r;
  logic [30:0]    s1_r;
  tce_pkg::sum_t  tv1_r, td1_r;
  tce_pkg::wide_t m_us_r, m_uds_r, m_num_r;
  tce_pkg::esum_t esum2_r, spart2_r;
  logic           neg2_r;
  logic [63:0]    mag2_r, dividend3_r;
  tce_pkg::div_side_t dside3_r;

  logic               div_v;
  tce_pkg::div_side_t div_side;
  logic [63:0]        quot;

  tce_pkg::acc_t cterm;
  logic          out_valid_r;
  logic [63:0]   energy_r, slope_r;

  assign en           = !out_valid_r || out_rsp.ready;
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tce_pkg::CFG_COUNT; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && cfg_index <= tce_pkg::REG_U_TWO) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    coef_use.t0 = coef_r[tce_pkg::REG_T_ZERO];
    coef_use.t1 = (MAX_DEGREE >= 1) ? coef_r[tce_pkg::REG_T_ONE]   : '0;
    coef_use.t2 = (MAX_DEGREE >= 2) ? coef_r[tce_pkg::REG_T_TWO]   : '0;
    coef_use.t3 = (MAX_DEGREE >= 3) ? coef_r[tce_pkg::REG_T_THREE] : '0;
    coef_use.u0 = coef_r[tce_pkg::REG_U_ZERO];
    coef_use.u1 = (MAX_DEGREE >= 2) ? coef_r[tce_pkg::REG_U_ONE]   : '0;
    coef_use.u2 = (MAX_DEGREE >= 3) ? coef_r[tce_pkg::REG_U_TWO]   : '0;
  end

  tce_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_req.valid),
    .in_cos    (in_req.cos_angle),
    .coef      (coef_use),
    .out_valid (poly_v),
    .out_poly  (poly_side),
    .out_rad   (poly_rad)
  );

  tce_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (poly_v),
    .in_side   (poly_side),
    .in_rad    (poly_rad),
    .out_valid (root_v),
    .out_side  (root_side),
    .out_root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= root_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r <= root_side;
      s0_r    <= (root < tce_pkg::SIN_FLOOR) ? tce_pkg::SIN_FLOOR : root;

      tv1_r   <= side0_r.tv;
      td1_r   <= side0_r.td;
      s1_r    <= s0_r;
      m_us_r  <= side0_r.uv * $signed({1'b0, s0_r});
      m_uds_r <= side0_r.ud * $signed({1'b0, s0_r});
      m_num_r <= side0_r.uv * side0_r.c;

      esum2_r  <= tce_pkg::esum_t'(tv1_r) + tce_pkg::esum_t'(tce_pkg::rnd30(m_us_r));
      spart2_r <= tce_pkg::esum_t'(td1_r) + tce_pkg::esum_t'(tce_pkg::rnd30(m_uds_r));
      neg2_r   <= m_num_r[67];
      mag2_r   <= m_num_r[67] ? 64'(-m_num_r) : 64'(m_num_r);
      s2_r     <= s1_r;

      dividend3_r    <= mag2_r + 64'(s2_r >> 1);
      s3_r           <= s2_r;
      dside3_r.esum  <= esum2_r;
      dside3_r.spart <= spart2_r;
      dside3_r.neg   <= neg2_r;
    end
  end

  tce_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v3_r),
    .in_side     (dside3_r),
    .in_dividend (dividend3_r),
    .in_divisor  (s3_r),
    .out_valid   (div_v),
    .out_side    (div_side),
    .out_quot    (quot)
  );

  assign cterm = div_side.neg ? $signed({2'b00, quot}) : -$signed({2'b00, quot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      energy_r <= tce_pkg::sat64(tce_pkg::acc_t'(div_side.esum));
      slope_r  <= tce_pkg::sat64(tce_pkg::acc_t'(div_side.spart) + cterm);
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.energy       = energy_r;
  assign out_rsp.energy_slope = slope_r;

endmodule

`default_nettype wire

### src/tce_poly.sv
// ----------------------------------------------------------------------------
// Torsion polynomial front end
// Clamp, cosine powers, rounded terms and polynomial sums in eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_poly (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_cos,
  input  tce_pkg::coef_set_t  coef,
  output logic                out_valid,
  output tce_pkg::poly_t      out_poly,
  output tce_pkg::rad_t       out_rad
);

  logic [7:0] vld_r;

  logic signed [31:0] c1_nxt;
  logic signed [31:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;
  logic signed [63:0] csq2_r, prod4_r;
  logic signed [31:0] p2_3_r, p2_4_r, p2_5_r, p3_5_r;
  tce_pkg::rad_t      rad3_r, rad4_r, rad5_r, rad6_r, rad7_r, rad8_r;

  logic signed [63:0] m_t1c_r, m_t2p2_r, m_t3p3_r, m_u1c_r, m_u2p2_r;
  logic signed [63:0] m_t2c_r, m_t3p2_r, m_u2c_r;

  tce_pkg::term_t a0_r, a1_r, a2_r, a3_r, d1_r, d2_r, d3_r;
  tce_pkg::term_t b0_r, b1_r, b2_r, e1_r, e2_r;

  tce_pkg::poly_t poly8_r;

  always_comb begin
    priority if (in_cos > tce_pkg::ONE_Q30) begin
      c1_nxt = tce_pkg::ONE_Q30;
    end else if (in_cos < tce_pkg::NEG_ONE_Q30) begin
      c1_nxt = tce_pkg::NEG_ONE_Q30;
    end else begin
      c1_nxt = in_cos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= c1_nxt;
      c2_r     <= c1_r;
      csq2_r   <= c1_r * c1_r;
      c3_r     <= c2_r;
      p2_3_r   <= 32'(tce_pkg::rnd30(tce_pkg::wide_t'(csq2_r)));
      rad3_r   <= tce_pkg::rad_t'(64'h1000_0000_0000_0000 - csq2_r);
      c4_r     <= c3_r;
      p2_4_r   <= p2_3_r;
      prod4_r  <= p2_3_r * c3_r;
      rad4_r   <= rad3_r;
      c5_r     <= c4_r;
      p2_5_r   <= p2_4_r;
      p3_5_r   <= 32'(tce_pkg::rnd30(tce_pkg::wide_t'(prod4_r)));
      rad5_r   <= rad4_r;
      c6_r     <= c5_r;
      rad6_r   <= rad5_r;
      m_t1c_r  <= coef.t1 * c5_r;
      m_t2p2_r <= coef.t2 * p2_5_r;
      m_t3p3_r <= coef.t3 * p3_5_r;
      m_u1c_r  <= coef.u1 * c5_r;
      m_u2p2_r <= coef.u2 * p2_5_r;
      m_t2c_r  <= coef.t2 * c5_r;
      m_t3p2_r <= coef.t3 * p2_5_r;
      m_u2c_r  <= coef.u2 * c5_r;
      c7_r     <= c6_r;
      rad7_r   <= rad6_r;
      a0_r     <= tce_pkg::term_t'(coef.t0);
      a1_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_t1c_r)));
      a2_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_t2p2_r)));
      a3_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_t3p3_r)));
      d1_r     <= tce_pkg::term_t'(coef.t1);
      d2_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_t2c_r) <<< 1));
      d3_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_t3p2_r)
                  + (tce_pkg::wide_t'(m_t3p2_r) <<< 1)));
      b0_r     <= tce_pkg::term_t'(coef.u0);
      b1_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_u1c_r)));
      b2_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_u2p2_r)));
      e1_r     <= tce_pkg::term_t'(coef.u1);
      e2_r     <= tce_pkg::term_t'(tce_pkg::rnd30(tce_pkg::wide_t'(m_u2c_r) <<< 1));
      poly8_r.c  <= c7_r;
      poly8_r.tv <= tce_pkg::sum_t'(a0_r) + tce_pkg::sum_t'(a1_r)
                  + tce_pkg::sum_t'(a2_r) + tce_pkg::sum_t'(a3_r);
      poly8_r.td <= tce_pkg::sum_t'(d1_r) + tce_pkg::sum_t'(d2_r) + tce_pkg::sum_t'(d3_r);
      poly8_r.uv <= tce_pkg::sum_t'(b0_r) + tce_pkg::sum_t'(b1_r) + tce_pkg::sum_t'(b2_r);
      poly8_r.ud <= tce_pkg::sum_t'(e1_r) + tce_pkg::sum_t'(e2_r);
      rad8_r     <= rad7_r;
    end
  end

  assign out_valid = vld_r[7];
  assign out_poly  = poly8_r;
  assign out_rad   = rad8_r;

endmodule

`default_nettype wire

### src/tce_sqrt.sv
// ----------------------------------------------------------------------------
// Torsion sine root pipeline
// Integer square root, one result bit per stage, with payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tce_pkg::poly_t in_side,
  input  tce_pkg::rad_t  in_rad,
  output logic           out_valid,
  output tce_pkg::poly_t out_side,
  output logic [30:0]    out_root
);

  localparam int N = tce_pkg::SQ_STEPS;

  logic           v_r    [1:N];
  tce_pkg::rad_t  x_r    [1:N];
  tce_pkg::rad_t  r_r    [1:N];
  tce_pkg::poly_t side_r [1:N];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_step
      localparam tce_pkg::rad_t BIT = tce_pkg::rad_t'(1) << (2 * (N - 1 - j));

      logic           lv;
      tce_pkg::rad_t  lx, lr, sum;
      tce_pkg::poly_t ls;
      logic           take;

      if (j == 0) begin : g_src
        assign lv = in_valid;
        assign lx = in_rad;
        assign lr = '0;
        assign ls = in_side;
      end else begin : g_src
        assign lv = v_r[j];
        assign lx = x_r[j];
        assign lr = r_r[j];
        assign ls = side_r[j];
      end

      assign sum  = lr + BIT;
      assign take = (lx >= sum);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j+1] <= 1'b0;
        end else if (en) begin
          v_r[j+1] <= lv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[j+1]    <= take ? lx - sum : lx;
          r_r[j+1]    <= take ? (lr >> 1) + BIT : lr >> 1;
          side_r[j+1] <= ls;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[N];
  assign out_side  = side_r[N];
  assign out_root  = r_r[N][30:0];

endmodule

`default_nettype wire

### src/tce_div.sv
// ----------------------------------------------------------------------------
// Torsion cosine term divider
// Restoring unsigned division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  tce_pkg::div_side_t in_side,
  input  logic [63:0]        in_dividend,
  input  logic [30:0]        in_divisor,
  output logic               out_valid,
  output tce_pkg::div_side_t out_side,
  output logic [63:0]        out_quot
);

  localparam int N = tce_pkg::DIV_STEPS;

  logic               v_r    [1:N];
  tce_pkg::rem_t      rem_r  [1:N];
  logic [63:0]        dq_r   [1:N];
  logic [30:0]        d_r    [1:N];
  tce_pkg::div_side_t side_r [1:N];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_step
      logic               lv;
      tce_pkg::rem_t      lrem;
      logic [63:0]        ldq;
      logic [30:0]        ld;
      tce_pkg::div_side_t ls;
      logic [31:0]        rsh, diff;
      logic               ge;

      if (j == 0) begin : g_src
        assign lv   = in_valid;
        assign lrem = '0;
        assign ldq  = in_dividend;
        assign ld   = in_divisor;
        assign ls   = in_side;
      end else begin : g_src
        assign lv   = v_r[j];
        assign lrem = rem_r[j];
        assign ldq  = dq_r[j];
        assign ld   = d_r[j];
        assign ls   = side_r[j];
      end

      assign rsh  = {lrem, ldq[63]};
      assign diff = rsh - {1'b0, ld};
      assign ge   = (rsh >= {1'b0, ld});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j+1] <= 1'b0;
        end else if (en) begin
          v_r[j+1] <= lv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1]  <= ge ? diff[30:0] : rsh[30:0];
          dq_r[j+1]   <= {ldq[62:0], ge};
          d_r[j+1]    <= ld;
          side_r[j+1] <= ls;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[N];
  assign out_side  = side_r[N];
  assign out_quot  = dq_r[N];

endmodule

`default_nettype wire

### src/tce_checker.sv
// ----------------------------------------------------------------------------
// Torsion energy core port checker
// Port-level properties of the core, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] energy,
  input logic [63:0] energy_slope
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(energy) && $stable(energy_slope))
    else $error("response changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without a response stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind torsion_chebyshev_energy_force_core tce_checker u_tce_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .energy       (out_rsp.energy),
  .energy_slope (out_rsp.energy_slope)
);

`default_nettype wire
